// File: sv/ber_pkg.sv
// shared types and codes of the ellipse rasterizer
`default_nettype none
package ber_pkg;

	// request command codes
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic capture;  // latch start request fields
		logic square;   // rx^2, ry^2
		logic mul;      // rx^2 * ry
		logic norm;     // unrounded start error
		logic init;     // round error, reset x, y, bx
		logic decide;   // pick step direction
		logic update;   // apply step, load point register
	} ber_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last_pt;  // decided step ends the ellipse
	} ber_sts_t;

endpackage
`default_nettype wire

// File: sv/ber_if.sv
// request and point channel interfaces of the ellipse rasterizer
`default_nettype none
interface ber_req_if #(
	parameter int RADIUS_BITS = 11,
	parameter int COORD_BITS  = 12
) ();
	logic                          valid;
	logic                          ready;
	logic                          command;
	logic signed [COORD_BITS-1:0]  center_x;
	logic signed [COORD_BITS-1:0]  center_y;
	logic        [RADIUS_BITS-1:0] radius_x;
	logic        [RADIUS_BITS-1:0] radius_y;
	logic                          draw_enable;

	modport source (
		output valid, command, center_x, center_y, radius_x, radius_y, draw_enable,
		input  ready
	);
	modport sink (
		input  valid, command, center_x, center_y, radius_x, radius_y, draw_enable,
		output ready
	);
endinterface

interface ber_pt_if #(
	parameter int RADIUS_BITS = 11,
	parameter int COORD_BITS  = 12
) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_BITS-1:0]  origin_x;
	logic signed [COORD_BITS-1:0]  origin_y;
	logic        [RADIUS_BITS-1:0] offset_x;
	logic        [RADIUS_BITS-1:0] offset_y;
	logic                          visible;
	logic                          done_res;

	modport source (
		output valid, origin_x, origin_y, offset_x, offset_y, visible, done_res,
		input  ready
	);
	modport sink (
		input  valid, origin_x, origin_y, offset_x, offset_y, visible, done_res,
		output ready
	);
endinterface
`default_nettype wire

// File: sv/ber_dp.sv
// error-term datapath of the ellipse rasterizer
`default_nettype none
module ber_dp #(
	parameter int RADIUS_BITS = 11,
	parameter int COORD_BITS  = 12
) (
	input  logic                          clk,
	input  ber_pkg::ber_cmd_t             cmd,
	output ber_pkg::ber_sts_t             sts,
	input  logic signed [COORD_BITS-1:0]  center_x,
	input  logic signed [COORD_BITS-1:0]  center_y,
	input  logic        [RADIUS_BITS-1:0] radius_x,
	input  logic        [RADIUS_BITS-1:0] radius_y,
	input  logic                          draw_enable,
	output logic signed [COORD_BITS-1:0]  origin_x,
	output logic signed [COORD_BITS-1:0]  origin_y,
	output logic        [RADIUS_BITS-1:0] offset_x,
	output logic        [RADIUS_BITS-1:0] offset_y,
	output logic                          visible,
	output logic                          done_res
);
	localparam int SQW = 2 * RADIUS_BITS;   // squared radius
	localparam int PRW = 3 * RADIUS_BITS;   // rx^2 * ry
	localparam int EW  = 3 * RADIUS_BITS + 8;
	localparam int XW  = RADIUS_BITS + 2;   // x may run one past rx
	localparam int YW  = RADIUS_BITS + 1;   // signed y

	// held start fields
	logic signed [COORD_BITS-1:0]  cx_q, cy_q;
	logic                          en_q;
	logic        [RADIUS_BITS-1:0] rx_q, ry_q;

	// run state: a = rx^2, b = ry^2, p = b*x, q = a*y
	logic [SQW-1:0]       a_q, b_q;
	logic [XW-1:0]        x_q;
	logic signed [YW-1:0] y_q;
	logic signed [EW-1:0] d_q, p_q, q_q;

	// decision stage
	logic                 h_s1, v_s1, last_s1;
	logic signed [EW-1:0] pn_s1, qn_s1;

	logic [SQW-1:0]       rx_sq, ry_sq;
	logic [PRW-1:0]       ary;
	logic signed [EW-1:0] a_e, b_e, t, d_rnd, inc_h, inc_v;
	logic                 d_neg, d_zero, t_pos, h_c, v_c;

	assign rx_sq = {{RADIUS_BITS{1'b0}}, rx_q} * {{RADIUS_BITS{1'b0}}, rx_q};
	assign ry_sq = {{RADIUS_BITS{1'b0}}, ry_q} * {{RADIUS_BITS{1'b0}}, ry_q};
	assign ary   = {{RADIUS_BITS{1'b0}}, a_q} * {{SQW{1'b0}}, ry_q};

	assign a_e = $signed({{(EW-SQW){1'b0}}, a_q});
	assign b_e = $signed({{(EW-SQW){1'b0}}, b_q});

	// n/2 with halves away from zero
	assign d_rnd = (d_q >>> 1) + $signed({{(EW-1){1'b0}}, d_q[0] & ~d_q[EW-1]});

	// direction test
	assign d_neg  = d_q[EW-1];
	assign d_zero = (d_q == '0);
	assign t      = (d_q <<< 1) + (d_neg ? (q_q <<< 1) : -(p_q <<< 1)) - b_e;
	assign t_pos  = ~t[EW-1] & (t != '0);
	assign h_c    = d_neg | d_zero | ~t_pos;
	assign v_c    = ~d_neg | t_pos;

	// error increments of the chosen moves
	assign inc_h = h_s1 ? ((pn_s1 <<< 1) + b_e) : '0;
	assign inc_v = v_s1 ? (a_e - (qn_s1 <<< 1)) : '0;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cx_q <= center_x;
			cy_q <= center_y;
			en_q <= draw_enable;
			rx_q <= radius_x;
			ry_q <= radius_y;
		end
		if (cmd.square) begin
			a_q <= rx_sq;
			b_q <= ry_sq;
		end
		if (cmd.mul) begin
			q_q <= $signed({{(EW-PRW){1'b0}}, ary});
		end
		if (cmd.norm) begin
			d_q <= a_e + b_e - (q_q <<< 2);
		end
		if (cmd.init) begin
			d_q <= d_rnd;
			x_q <= '0;
			y_q <= $signed({1'b0, ry_q});
			p_q <= '0;
		end
		if (cmd.decide) begin
			h_s1    <= h_c;
			v_s1    <= v_c;
			last_s1 <= v_c & (y_q == '0);
			pn_s1   <= p_q + b_e;
			qn_s1   <= q_q - a_e;
		end
		if (cmd.update) begin
			origin_x <= cx_q;
			origin_y <= cy_q;
			offset_x <= x_q[RADIUS_BITS-1:0];
			offset_y <= y_q[RADIUS_BITS-1:0];
			visible  <= en_q;
			done_res <= last_s1;
			x_q      <= x_q + {{(XW-1){1'b0}}, h_s1};
			y_q      <= last_s1 ? '0 : (y_q - $signed({{(YW-1){1'b0}}, v_s1}));
			if (h_s1) begin
				p_q <= pn_s1;
			end
			if (v_s1) begin
				q_q <= qn_s1;
			end
			d_q <= d_q + inc_h + inc_v;
		end
	end

	assign sts.last_pt = last_s1;

endmodule
`default_nettype wire

// File: sv/ber_ctrl.sv
// sequencing controller of the ellipse rasterizer
`default_nettype none
module ber_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              command,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  ber_pkg::ber_sts_t sts,
	output ber_pkg::ber_cmd_t cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SQR  = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_NORM = 3'd3;
	localparam logic [2:0] S_INIT = 3'd4;
	localparam logic [2:0] S_DEC  = 3'd5;
	localparam logic [2:0] S_UPD  = 3'd6;

	logic [2:0] state_q, state_d;
	logic       active_q, out_valid_q;
	logic       out_free, in_fire, is_start, act_eff;

	assign out_free = ~out_valid_q | out_ready;
	assign in_ready = (state_q == S_IDLE) | ((state_q == S_UPD) & out_free);
	assign in_fire  = in_valid & in_ready;
	assign is_start = (command == ber_pkg::CMD_START);
	// run still open after a step applied this cycle
	assign act_eff  = (state_q == S_UPD) ? (active_q & ~sts.last_pt) : active_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE, S_UPD: begin
				if (state_q == S_IDLE || out_free) begin
					state_d = S_IDLE;
					if (in_fire) begin
						if (is_start) begin
							state_d = S_SQR;
						end else if (act_eff) begin
							state_d = S_DEC;
						end
					end
				end
			end
			S_SQR:   state_d = S_MUL;
			S_MUL:   state_d = S_NORM;
			S_NORM:  state_d = S_INIT;
			S_INIT:  state_d = S_IDLE;
			S_DEC:   state_d = S_UPD;
			default: state_d = S_IDLE;
		endcase
	end

	assign cmd.capture = in_fire & is_start;
	assign cmd.square  = (state_q == S_SQR);
	assign cmd.mul     = (state_q == S_MUL);
	assign cmd.norm    = (state_q == S_NORM);
	assign cmd.init    = (state_q == S_INIT);
	assign cmd.decide  = (state_q == S_DEC);
	assign cmd.update  = (state_q == S_UPD) & out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.capture) begin
				active_q <= 1'b1;
			end else if (cmd.update && sts.last_pt) begin
				active_q <= 1'b0;
			end
			if (cmd.update) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	// a point is only produced inside an open run
	a_update_active: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> active_q)
		else $error("point produced with no ellipse in progress");

	// a start request always enters the load sequence
	a_start_loads: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == S_SQR) && active_q)
		else $error("start request did not begin loading");

	// a last point closes the run
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update && sts.last_pt && !cmd.capture) |=> !active_q)
		else $error("run still open after last point");

	// the point register is never overwritten while still held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> (!out_valid_q || out_ready))
		else $error("held point overwritten");

endmodule
`default_nettype wire

// File: sv/bresenham_ellipse_rasterizer.sv
// top level of the first-quadrant bresenham ellipse rasterizer
// usage:
//   req_ch carries requests. command start latches center, radii and draw
//   enable and opens a new ellipse; it produces no point. command step
//   produces the current point on pt_ch and moves one pixel along the arc.
//   a step with no open ellipse (before any start or after the last point)
//   is taken and dropped. done_res marks the last point of a run.
// sequencing:
//   a start is accepted, then passes the setup states for the squares,
//   rx^2*ry product, error sum and rounding before the next request is taken.
//   a step runs a direction decision, then an update; the
//   point appears in the output register at the update, and the
//   next request is taken in that same cycle. the rate is set by the error
//   term recurrence, one point per decide/update pass.
// stalls:
//   the output register holds one point. while it is waiting the block still
//   takes the next request and computes its decision, then waits in the update
//   cycle until the register frees. a start may enter while a point is held.
// reset:
//   arst_n clears the controller: no ellipse open, no point held.
`default_nettype none
module bresenham_ellipse_rasterizer #(
	parameter int RADIUS_BITS = 11,
	parameter int COORD_BITS  = 12
) (
	input  logic   clk,
	input  logic   arst_n,
	ber_req_if.sink  req_ch,
	ber_pt_if.source pt_ch
);
	ber_pkg::ber_cmd_t cmd;
	ber_pkg::ber_sts_t sts;

	// sequencing: handshakes, run flag, output valid
	ber_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req_ch.valid),
		.command   (req_ch.command),
		.in_ready  (req_ch.ready),
		.out_valid (pt_ch.valid),
		.out_ready (pt_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// error-term arithmetic and point register
	ber_dp #(
		.RADIUS_BITS (RADIUS_BITS),
		.COORD_BITS  (COORD_BITS)
	) u_dp (
		.clk         (clk),
		.cmd         (cmd),
		.sts         (sts),
		.center_x    (req_ch.center_x),
		.center_y    (req_ch.center_y),
		.radius_x    (req_ch.radius_x),
		.radius_y    (req_ch.radius_y),
		.draw_enable (req_ch.draw_enable),
		.origin_x    (pt_ch.origin_x),
		.origin_y    (pt_ch.origin_y),
		.offset_x    (pt_ch.offset_x),
		.offset_y    (pt_ch.offset_y),
		.visible     (pt_ch.visible),
		.done_res    (pt_ch.done_res)
	);

endmodule
`default_nettype wire
